[sv/gpc_pkg.sv]
package gpc_pkg;

  localparam int unsigned FilterStages = 3;
  localparam logic [22:0] DegPerRadQ16 = 23'd3754937;

  localparam logic [12:0] ResXReset = 13'd1920;
  localparam logic [12:0] ResYReset = 13'd1080;
  localparam logic [7:0] ClosureThresholdReset = 8'd128;
  localparam logic [15:0] BlinkMaxReset = 16'd500;
  localparam logic [15:0] PairMaxReset = 16'd1500;
  localparam logic [15:0] PairMinReset = 16'd10;
  localparam logic [6:0] SmoothDivisorReset = 7'd5;
  localparam logic [6:0] HalfSpanReset = 7'd10;

  typedef enum logic [2:0] {
    REG_RES_X = 3'd0,
    REG_RES_Y = 3'd1,
    REG_CLOSURE_THRESHOLD = 3'd2,
    REG_BLINK_MAX = 3'd3,
    REG_PAIR_MAX = 3'd4,
    REG_PAIR_MIN = 3'd5,
    REG_SMOOTH_DIVISOR = 3'd6,
    REG_HALF_SPAN = 3'd7
  } reg_index_t;

  typedef enum logic [1:0] {
    EV_NONE = 2'd0,
    EV_MOVE = 2'd1,
    EV_CLICK = 2'd2
  } event_kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_MAP_MUL,
    ST_MAP_DIV,
    ST_MAP_DONE,
    ST_FILT_START,
    ST_FILT_DIV,
    ST_FILT_DONE,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic decide;
    logic mul_start;
    logic div_start;
    logic map_store;
    logic filt_store;
    logic out_load;
    logic axis;
    logic [2:0] stage;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic run;
  } status_t;

endpackage

[sv/gpc_if.sv]
interface gpc_in_if;
  logic valid;
  logic ready;
  logic [7:0] left_closure;
  logic [7:0] right_closure;
  logic [2:0] gaze_quality;
  logic signed [15:0] head_pitch;
  logic signed [15:0] head_yaw;
  logic [31:0] time_ms;
  modport source (output valid, left_closure, right_closure, gaze_quality, head_pitch,
    head_yaw, time_ms, input ready);
  modport sink (input valid, left_closure, right_closure, gaze_quality, head_pitch,
    head_yaw, time_ms, output ready);
endinterface

interface gpc_out_if;
  logic valid;
  logic ready;
  logic [1:0] event_kind;
  logic [12:0] pointer_x;
  logic [12:0] pointer_y;
  modport source (output valid, event_kind, pointer_x, pointer_y, input ready);
  modport sink (input valid, event_kind, pointer_x, pointer_y, output ready);
endinterface

interface gpc_cfg_if;
  logic valid;
  logic ready;
  logic [2:0] index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[sv/gpc_divider.sv]
module gpc_divider #(
  parameter int unsigned NumW = 48,
  parameter int unsigned DenW = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [NumW-1:0] num,
  input  logic [DenW-1:0] den,
  output logic done,
  output logic [NumW-1:0] quo
);
  localparam int unsigned CntW = $clog2(NumW + 1);
  logic [NumW-1:0] q;
  logic [DenW:0] rem;
  logic [DenW-1:0] d;
  logic [CntW-1:0] cnt;
  logic busy;
  logic [DenW:0] trial;

  assign trial = {rem[DenW-1:0], q[NumW-1]};
  assign quo = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= CntW'(NumW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q <= num;
      rem <= '0;
      d <= den;
    end else if (busy) begin
      if (trial >= {1'b0, d}) begin
        rem <= trial - {1'b0, d};
        q <= {q[NumW-2:0], 1'b1};
      end else begin
        rem <= trial;
        q <= {q[NumW-2:0], 1'b0};
      end
    end
  end
endmodule

[sv/gpc_datapath.sv]
module gpc_datapath #(
  parameter int unsigned FILTER_STAGES = gpc_pkg::FilterStages
) (
  input  logic clk,
  input  logic rst,
  gpc_in_if.sink in_ch,
  gpc_cfg_if.sink cfg_ch,
  input  gpc_pkg::cmd_t cmd,
  output gpc_pkg::status_t status,
  output logic [1:0] event_kind,
  output logic [12:0] pointer_x,
  output logic [12:0] pointer_y
);
  localparam int unsigned StW = (FILTER_STAGES > 1) ? $clog2(FILTER_STAGES) : 1;

  logic [12:0] res_x, res_y;
  logic [7:0] thr;
  logic [15:0] blink_max, pair_max, pair_min;
  logic [6:0] sdiv, hspan;

  logic [7:0] l_c, r_c;
  logic [2:0] qual;
  logic signed [15:0] pitch, yaw;
  logic [31:0] t_s;

  logic blink_phase, pair_phase;
  logic [31:0] close_time, first_time;
  logic [12:0] saved_x, saved_y;
  logic [20:0] stage_x [FILTER_STAGES];
  logic [20:0] stage_y [FILTER_STAGES];
  logic [21:0] mapped [2];

  logic [27:0] m1;
  logic [49:0] prod;
  logic [20:0] diff_mag;
  logic diff_neg;

  logic [49:0] div_num;
  logic [31:0] div_den;
  logic div_done;
  logic [49:0] div_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_x <= gpc_pkg::ResXReset;
      res_y <= gpc_pkg::ResYReset;
      thr <= gpc_pkg::ClosureThresholdReset;
      blink_max <= gpc_pkg::BlinkMaxReset;
      pair_max <= gpc_pkg::PairMaxReset;
      pair_min <= gpc_pkg::PairMinReset;
      sdiv <= gpc_pkg::SmoothDivisorReset;
      hspan <= gpc_pkg::HalfSpanReset;
    end else if (cfg_ch.valid) begin
      case (gpc_pkg::reg_index_t'(cfg_ch.index))
        gpc_pkg::REG_RES_X: res_x <= cfg_ch.data[12:0];
        gpc_pkg::REG_RES_Y: res_y <= cfg_ch.data[12:0];
        gpc_pkg::REG_CLOSURE_THRESHOLD: thr <= cfg_ch.data[7:0];
        gpc_pkg::REG_BLINK_MAX: blink_max <= cfg_ch.data;
        gpc_pkg::REG_PAIR_MAX: pair_max <= cfg_ch.data;
        gpc_pkg::REG_PAIR_MIN: pair_min <= cfg_ch.data;
        gpc_pkg::REG_SMOOTH_DIVISOR: sdiv <= cfg_ch.data[6:0];
        gpc_pkg::REG_HALF_SPAN: hspan <= cfg_ch.data[6:0];
        default: ;
      endcase
    end
  end
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      l_c <= in_ch.left_closure;
      r_c <= in_ch.right_closure;
      qual <= in_ch.gaze_quality;
      pitch <= in_ch.head_pitch;
      yaw <= in_ch.head_yaw;
      t_s <= in_ch.time_ms;
    end
  end

  logic closed, opened, blink_now, run_now, click_now;
  logic [31:0] close_gap, pair_gap;
  always_comb begin
    closed = (l_c > thr) && (r_c > thr);
    opened = (l_c < thr) && (r_c < thr);
    close_gap = t_s - close_time;
    pair_gap = t_s - first_time;
    blink_now = blink_phase && opened && (close_gap < {16'd0, blink_max});
    click_now = blink_now && pair_phase && !(pair_gap > {16'd0, pair_max})
      && (pair_gap >= {16'd0, pair_min});
    run_now = blink_now ? !pair_phase : (qual != 3'd0);
  end

  logic dec_blink, dec_first, dec_click;
  always_ff @(posedge clk) begin
    if (rst) begin
      blink_phase <= 1'b0;
      pair_phase <= 1'b0;
      close_time <= '0;
      first_time <= '0;
      dec_blink <= 1'b0;
      dec_first <= 1'b0;
      dec_click <= 1'b0;
    end else if (cmd.decide) begin
      dec_blink <= blink_now;
      dec_first <= blink_now && !pair_phase;
      dec_click <= click_now;
      if (!blink_phase) begin
        if (closed) begin
          close_time <= t_s;
          blink_phase <= 1'b1;
        end
      end else if (opened) begin
        blink_phase <= 1'b0;
      end
      if (blink_now) begin
        if (!pair_phase) begin
          first_time <= t_s;
          pair_phase <= 1'b1;
        end else if (pair_gap > {16'd0, pair_max} || click_now) begin
          pair_phase <= 1'b0;
        end
      end
    end
  end

  logic signed [15:0] ang;
  logic [15:0] mag;
  logic [12:0] res_a;
  logic [6:0] hs_eff;
  assign ang = cmd.axis ? pitch : yaw;
  assign res_a = cmd.axis ? res_y : res_x;
  assign mag = ang[15] ? 16'(-ang) : 16'(ang);
  assign hs_eff = (hspan == 7'd0) ? 7'd1 : hspan;

  logic mul_done;
  always_ff @(posedge clk) begin
    if (rst) begin
      mul_done <= 1'b0;
    end else begin
      mul_done <= cmd.mul_start;
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.mul_start) begin
      m1 <= 28'(mag) * 28'(res_a);
    end
  end
  assign prod = 50'(m1) * 50'(gpc_pkg::DegPerRadQ16);

  assign status = '{mul_done: mul_done, div_done: div_done, run: run_now};

  logic [20:0] src_v, cur_v;
  logic [6:0] sd_eff;
  assign sd_eff = (sdiv == 7'd0) ? 7'd1 : sdiv;
  always_comb begin
    if (cmd.stage[StW-1:0] == '0) begin
      src_v = mapped[cmd.axis][20:0];
    end else if (cmd.axis) begin
      src_v = stage_y[cmd.stage[StW-1:0] - 1'b1];
    end else begin
      src_v = stage_x[cmd.stage[StW-1:0] - 1'b1];
    end
    cur_v = cmd.axis ? stage_y[cmd.stage[StW-1:0]] : stage_x[cmd.stage[StW-1:0]];
  end

  always_comb begin
    if (cmd.mul_start || mul_done) begin
      div_num = prod + {22'd0, hs_eff, 21'd0};
      div_den = {3'd0, hs_eff, 22'd0};
    end else begin
      div_num = {29'd0, diff_mag};
      div_den = {25'd0, sd_eff};
    end
  end

  always_comb begin
    diff_neg = src_v < cur_v;
    diff_mag = diff_neg ? (cur_v - src_v) : (src_v - cur_v);
  end

  gpc_divider #(.NumW(50), .DenW(32)) u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_q)
  );

  logic [21:0] center, topv;
  logic signed [51:0] cval;
  assign center = {2'd0, res_a, 7'd0};
  assign topv = {1'b0, res_a, 8'd0};
  always_comb begin
    if (ang[15]) begin
      cval = $signed({30'd0, center}) + $signed({2'd0, div_q});
    end else begin
      cval = $signed({30'd0, center}) - $signed({2'd0, div_q});
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.map_store) begin
      if (cval < 0) begin
        mapped[cmd.axis] <= '0;
      end else if (cval > $signed({30'd0, topv})) begin
        mapped[cmd.axis] <= topv;
      end else begin
        mapped[cmd.axis] <= cval[21:0];
      end
    end
  end

  logic [20:0] new_v;
  assign new_v = diff_neg ? 21'(cur_v - div_q[20:0]) : 21'(cur_v + div_q[20:0]);
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < FILTER_STAGES; i++) begin
        stage_x[i] <= '0;
        stage_y[i] <= '0;
      end
    end else if (cmd.filt_store) begin
      if (cmd.axis) begin
        stage_y[cmd.stage[StW-1:0]] <= new_v;
      end else begin
        stage_x[cmd.stage[StW-1:0]] <= new_v;
      end
    end
  end

  logic [12:0] fx, fy;
  assign fx = stage_x[FILTER_STAGES-1][20:8];
  assign fy = stage_y[FILTER_STAGES-1][20:8];
  always_ff @(posedge clk) begin
    if (rst) begin
      saved_x <= '0;
      saved_y <= '0;
    end else if (cmd.out_load && dec_first) begin
      saved_x <= fx;
      saved_y <= fy;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (dec_click) begin
        event_kind <= gpc_pkg::EV_CLICK;
        pointer_x <= saved_x;
        pointer_y <= saved_y;
      end else if (!dec_blink && qual != 3'd0) begin
        event_kind <= gpc_pkg::EV_MOVE;
        pointer_x <= fx;
        pointer_y <= fy;
      end else begin
        event_kind <= gpc_pkg::EV_NONE;
        pointer_x <= '0;
        pointer_y <= '0;
      end
    end
  end
endmodule

[sv/gpc_control.sv]
module gpc_control #(
  parameter int unsigned FILTER_STAGES = gpc_pkg::FilterStages
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  gpc_pkg::status_t status,
  output gpc_pkg::cmd_t cmd
);
  gpc_pkg::state_t state, state_next;
  logic axis, axis_next;
  logic [2:0] stage, stage_next;
  logic out_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gpc_pkg::ST_IDLE;
      axis <= 1'b0;
      stage <= '0;
      out_full <= 1'b0;
    end else begin
      state <= state_next;
      axis <= axis_next;
      stage <= stage_next;
      if (state == gpc_pkg::ST_OUT) begin
        out_full <= 1'b1;
      end else if (out_ready) begin
        out_full <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    axis_next = axis;
    stage_next = stage;
    case (state)
      gpc_pkg::ST_IDLE: begin
        if (in_valid) state_next = gpc_pkg::ST_DECIDE;
      end
      gpc_pkg::ST_DECIDE: begin
        axis_next = 1'b0;
        stage_next = '0;
        state_next = status.run ? gpc_pkg::ST_MAP_MUL : gpc_pkg::ST_OUT;
      end
      gpc_pkg::ST_MAP_MUL: begin
        if (status.mul_done) state_next = gpc_pkg::ST_MAP_DIV;
      end
      gpc_pkg::ST_MAP_DIV: begin
        if (status.div_done) state_next = gpc_pkg::ST_MAP_DONE;
      end
      gpc_pkg::ST_MAP_DONE: begin
        if (axis) begin
          axis_next = 1'b0;
          state_next = gpc_pkg::ST_FILT_START;
        end else begin
          axis_next = 1'b1;
          state_next = gpc_pkg::ST_MAP_MUL;
        end
      end
      gpc_pkg::ST_FILT_START: begin
        state_next = gpc_pkg::ST_FILT_DIV;
      end
      gpc_pkg::ST_FILT_DIV: begin
        if (status.div_done) state_next = gpc_pkg::ST_FILT_DONE;
      end
      gpc_pkg::ST_FILT_DONE: begin
        if (!axis) begin
          axis_next = 1'b1;
          state_next = gpc_pkg::ST_FILT_START;
        end else if (stage == 3'(FILTER_STAGES - 1)) begin
          state_next = gpc_pkg::ST_OUT;
        end else begin
          axis_next = 1'b0;
          stage_next = stage + 1'b1;
          state_next = gpc_pkg::ST_FILT_START;
        end
      end
      gpc_pkg::ST_OUT: begin
        if (!out_full || out_ready) state_next = gpc_pkg::ST_IDLE;
      end
      default: state_next = gpc_pkg::ST_IDLE;
    endcase
  end

  logic entering;
  assign entering = (state_next != state);

  always_comb begin
    cmd = '0;
    cmd.axis = axis;
    cmd.stage = stage;
    in_ready = (state == gpc_pkg::ST_IDLE);
    out_valid = out_full;
    case (state)
      gpc_pkg::ST_IDLE: cmd.load = in_valid;
      gpc_pkg::ST_DECIDE: cmd.decide = 1'b1;
      gpc_pkg::ST_MAP_MUL: begin
        cmd.mul_start = !status.mul_done && !entering;
        cmd.div_start = status.mul_done;
      end
      gpc_pkg::ST_MAP_DIV: cmd.map_store = status.div_done;
      gpc_pkg::ST_FILT_START: cmd.div_start = 1'b1;
      gpc_pkg::ST_FILT_DIV: cmd.filt_store = status.div_done;
      gpc_pkg::ST_OUT: cmd.out_load = !out_full || out_ready;
      default: ;
    endcase
  end
endmodule

[sv/gaze_pointer_click_controller.sv]
// A sample that leaves the filter alone goes from ST_DECIDE straight to ST_OUT; when
// the filter runs, two mappings and six filter steps come first, each set by the
// shared 50-step bit-serial divider.
// One sample is in work at a time; the next is taken in the idle cycle after the result
// is registered, and ST_OUT holds while the output still holds an unaccepted result.
// Synchronous reset restores the configuration registers to defaults and clears the filter and detectors.
module gaze_pointer_click_controller #(
  parameter int unsigned FILTER_STAGES = gpc_pkg::FilterStages
) (
  input  logic clk,
  input  logic rst,
  gpc_in_if.sink in_ch,
  gpc_out_if.source out_ch,
  gpc_cfg_if.sink cfg_ch
);
  gpc_pkg::cmd_t cmd;
  gpc_pkg::status_t status;

  gpc_control #(.FILTER_STAGES(FILTER_STAGES)) u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .status(status), .cmd(cmd)
  );

  gpc_datapath #(.FILTER_STAGES(FILTER_STAGES)) u_dp (
    .clk(clk), .rst(rst), .in_ch(in_ch), .cfg_ch(cfg_ch), .cmd(cmd), .status(status),
    .event_kind(out_ch.event_kind), .pointer_x(out_ch.pointer_x),
    .pointer_y(out_ch.pointer_y)
  );
endmodule
